// ===== design/isbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU scale and bias calibration package
// Shared widths, constants, word types and the fixed-point scaling helpers.
// ----------------------------------------------------------------------------
package isbc_pkg;

  // Calibration length: one dropped sample, then CALIB_COUNT-1 summed samples.
  localparam int CALIB_COUNT = 65;

  localparam int N_AXES   = 6;
  localparam int N_ACCEL  = 3;
  localparam int AX_AZ    = 2;
  localparam int RAW_W    = 16;
  localparam int STATUS_W = 8;
  localparam int OUT_W    = 32;

  localparam logic [STATUS_W-1:0] STATUS_READY_MASK = 8'h03;

  // Scale factors: 9.80665 in Q8.24 and pi/180 in Q0.32.
  localparam int ACC_K_W = 29;
  localparam int GYR_K_W = 28;
  localparam logic signed [ACC_K_W-1:0] ONE_G_Q24   = ACC_K_W'(164528285);
  localparam logic signed [GYR_K_W-1:0] DEG2RAD_Q32 = GYR_K_W'(74961321);
  localparam int ONE_G_Q16 = 642689;

  localparam int PROD_W  = 44;
  localparam int SHIFT_W = 5;
  localparam int ACC_SHIFT_BASE = 22;
  localparam int GYR_SHIFT_BASE = 27;

  // Largest converted magnitude is about 1.03e7 (accel, 16 g), so 25 bits signed.
  localparam int PHYS_W = 25;
  localparam int SUM_W  = PHYS_W + $clog2(CALIB_COUNT);
  localparam int OFF_W  = PHYS_W + 1;
  localparam int SUMO_W = OFF_W + 1;

  localparam int CNT_W    = $clog2(CALIB_COUNT + 1);
  localparam int DIVISOR  = CALIB_COUNT - 1;
  localparam int DIV_HALF = DIVISOR / 2;
  localparam int NUM_W    = SUM_W + 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration registers.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int ACC_RANGE_W = 2;
  localparam int GYR_RANGE_W = 3;
  localparam logic [ACC_RANGE_W-1:0] ACC_RANGE_RST = 2'd3;
  localparam logic [GYR_RANGE_W-1:0] GYR_RANGE_RST = 3'd3;
  localparam logic REG_IDX_ACCEL = 1'b0;
  localparam logic REG_IDX_GYRO  = 1'b1;

  // What the back end does with a word.
  typedef enum logic [2:0] {
    CLS_HOLD   = 3'd0,
    CLS_DROP   = 3'd1,
    CLS_ACC    = 3'd2,
    CLS_FINISH = 3'd3,
    CLS_APPLY  = 3'd4
  } cls_t;

  typedef struct packed {
    cls_t                          cls;
    logic [N_AXES-1:0][PHYS_W-1:0] phys;
  } entry_t;

  function automatic logic signed [PROD_W-1:0] mul_accel(input logic signed [RAW_W-1:0] raw);
    logic signed [PROD_W-1:0] a;
    logic signed [PROD_W-1:0] c;
    a = PROD_W'(raw);
    c = PROD_W'(ONE_G_Q24);
    return a * c;
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_gyro(input logic signed [RAW_W-1:0] raw);
    logic signed [PROD_W-1:0] a;
    logic signed [PROD_W-1:0] c;
    a = PROD_W'(raw);
    c = PROD_W'(DEG2RAD_Q32);
    return a * c;
  endfunction

  // Shift right by k with rounding to nearest, ties away from zero.
  function automatic logic signed [PHYS_W-1:0] round_shr(input logic signed [PROD_W-1:0] p,
                                                          input logic [SHIFT_W-1:0] k);
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] t;
    half = PROD_W'(1) << (k - SHIFT_W'(1));
    t    = p + half - PROD_W'(p[PROD_W-1]);
    return PHYS_W'(t >>> k);
  endfunction

endpackage
`default_nettype wire

// ===== design/isbc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU calibration front end
// Accepts samples, classifies them and converts them to physical units.
// ----------------------------------------------------------------------------
module isbc_front (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::RAW_W-1:0] in_raw,
  input  logic [isbc_pkg::STATUS_W-1:0]               in_status,
  input  logic [isbc_pkg::ACC_RANGE_W-1:0]            accel_range,
  input  logic [isbc_pkg::GYR_RANGE_W-1:0]            gyro_range,
  input  logic                                        q_full,
  output logic                                        q_push,
  output isbc_pkg::entry_t                            q_entry
);

  logic                                    s1_v_r;
  logic                                    s1_v_nxt;
  isbc_pkg::cls_t                          s1_cls_r;
  logic signed [isbc_pkg::PROD_W-1:0]      s1_prod_r [isbc_pkg::N_AXES];
  logic [isbc_pkg::CNT_W-1:0]              cnt_r;
  logic [isbc_pkg::CNT_W-1:0]              cnt_nxt;
  logic                                    done_r;
  logic                                    done_nxt;
  isbc_pkg::cls_t                          cls;
  logic                                    accept;
  logic                                    smp_ready;
  logic [isbc_pkg::SHIFT_W-1:0]            k_acc;
  logic [isbc_pkg::SHIFT_W-1:0]            k_gyr;

  assign q_push   = s1_v_r && !q_full;
  assign in_ready = !s1_v_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign s1_v_nxt = accept || (s1_v_r && !q_push);

  // The calibration sequence depends only on the order of ready samples,
  // so the front end tracks it and tags every word.
  always_comb begin
    smp_ready = |(in_status & isbc_pkg::STATUS_READY_MASK);
    cls       = isbc_pkg::CLS_HOLD;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    if (smp_ready) begin
      if (done_r) begin
        cls = isbc_pkg::CLS_APPLY;
      end else if (cnt_r == '0) begin
        cls     = isbc_pkg::CLS_DROP;
        cnt_nxt = isbc_pkg::CNT_W'(1);
      end else if (cnt_r < isbc_pkg::CNT_W'(isbc_pkg::CALIB_COUNT)) begin
        cls     = isbc_pkg::CLS_ACC;
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        cls      = isbc_pkg::CLS_FINISH;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (accept) begin
        cnt_r  <= cnt_nxt;
        done_r <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cls_r <= cls;
      for (int i = 0; i < isbc_pkg::N_ACCEL; i++) begin
        s1_prod_r[i] <= isbc_pkg::mul_accel($signed(in_raw[i]));
        s1_prod_r[i + isbc_pkg::N_ACCEL] <=
          isbc_pkg::mul_gyro($signed(in_raw[i + isbc_pkg::N_ACCEL]));
      end
    end
  end

  assign k_acc = isbc_pkg::SHIFT_W'(isbc_pkg::ACC_SHIFT_BASE) - isbc_pkg::SHIFT_W'(accel_range);
  assign k_gyr = isbc_pkg::SHIFT_W'(isbc_pkg::GYR_SHIFT_BASE) - isbc_pkg::SHIFT_W'(gyro_range);

  always_comb begin
    q_entry.cls = s1_cls_r;
    for (int i = 0; i < isbc_pkg::N_ACCEL; i++) begin
      q_entry.phys[i] = isbc_pkg::round_shr(s1_prod_r[i], k_acc);
      q_entry.phys[i + isbc_pkg::N_ACCEL] =
        isbc_pkg::round_shr(s1_prod_r[i + isbc_pkg::N_ACCEL], k_gyr);
    end
  end

endmodule
`default_nettype wire

// ===== design/isbc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU calibration word queue
// Short first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
module isbc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  isbc_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output isbc_pkg::entry_t pop_data
);

  isbc_pkg::entry_t              mem_r [isbc_pkg::Q_DEPTH];
  logic [isbc_pkg::Q_PTR_W-1:0]  wr_ptr_r;
  logic [isbc_pkg::Q_PTR_W-1:0]  rd_ptr_r;
  logic [isbc_pkg::Q_CNT_W-1:0]  cnt_r;
  logic [isbc_pkg::Q_CNT_W-1:0]  cnt_nxt;

  function automatic logic [isbc_pkg::Q_PTR_W-1:0] ptr_inc(input logic [isbc_pkg::Q_PTR_W-1:0] p);
    return (p == isbc_pkg::Q_PTR_W'(isbc_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (cnt_r == isbc_pkg::Q_CNT_W'(isbc_pkg::Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/isbc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU calibration mean divider
// Turns the six axis sums into rounded, negated means and holds them as
// the offsets.
// ----------------------------------------------------------------------------
module isbc_div (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               start,
  input  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::SUM_W-1:0]   sums,
  output logic [isbc_pkg::N_AXES-1:0][isbc_pkg::OFF_W-1:0]   offsets
);

  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::OFF_W-1:0]  offsets_r;
  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::OFF_W-1:0]  offsets_nxt;
  logic [isbc_pkg::NUM_W-1:0]    sx [isbc_pkg::N_AXES];
  logic [isbc_pkg::NUM_W-1:0]    mag [isbc_pkg::N_AXES];
  logic [isbc_pkg::NUM_W-1:0]    rnd [isbc_pkg::N_AXES];
  logic [isbc_pkg::OFF_W-1:0]    q [isbc_pkg::N_AXES];

  assign offsets = offsets_r;

  always_comb begin
    for (int i = 0; i < isbc_pkg::N_AXES; i++) begin
      // Magnitude plus half the divisor gives round-half-away-from-zero.
      sx[i]          = isbc_pkg::NUM_W'($signed(sums[i]));
      mag[i]         = sx[i][isbc_pkg::NUM_W-1] ? -sx[i] : sx[i];
      rnd[i]         = mag[i] + isbc_pkg::NUM_W'(isbc_pkg::DIV_HALF);
      // The divisor is a power of two, so the quotient is a plain shift.
      q[i]           = isbc_pkg::OFF_W'(rnd[i] / isbc_pkg::NUM_W'(isbc_pkg::DIVISOR));
      offsets_nxt[i] = sx[i][isbc_pkg::NUM_W-1] ? q[i] : -q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offsets_r <= '0;
    end else if (start) begin
      offsets_r <= offsets_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/isbc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU calibration back end
// Accumulates calibration sums, applies offsets and holds the result word.
// ----------------------------------------------------------------------------
module isbc_back (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               pop_valid,
  input  isbc_pkg::entry_t                                   pop_data,
  output logic                                               pop,
  input  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::OFF_W-1:0]   offsets,
  output logic                                               div_start,
  output logic [isbc_pkg::N_AXES-1:0][isbc_pkg::SUM_W-1:0]   sums,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output logic [isbc_pkg::N_AXES-1:0][isbc_pkg::OUT_W-1:0]   held,
  output logic                                               out_calibrated,
  output logic                                               out_fresh
);

  logic                                                  out_v_r;
  logic                                                  done_r;
  logic                                                  fresh_r;
  logic signed [isbc_pkg::SUM_W-1:0]                     sums_r [isbc_pkg::N_AXES];
  logic signed [isbc_pkg::SUM_W-1:0]                     sums_nxt [isbc_pkg::N_AXES];
  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::OUT_W-1:0]      held_r;
  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::OUT_W-1:0]      held_nxt;
  logic signed [isbc_pkg::SUMO_W-1:0]                    corr [isbc_pkg::N_AXES];
  logic                                                  is_apply;

  assign pop       = pop_valid && (!out_v_r || out_ready);
  assign div_start = pop && (pop_data.cls == isbc_pkg::CLS_FINISH);
  assign is_apply  = (pop_data.cls == isbc_pkg::CLS_APPLY);

  assign out_valid      = out_v_r;
  assign held           = held_r;
  assign out_calibrated = done_r;
  assign out_fresh      = fresh_r;

  always_comb begin
    for (int i = 0; i < isbc_pkg::N_AXES; i++) begin
      sums[i]     = sums_r[i];
      sums_nxt[i] = sums_r[i] + isbc_pkg::SUM_W'($signed(pop_data.phys[i]));
      if (i == isbc_pkg::AX_AZ) begin
        sums_nxt[i] = sums_nxt[i] - isbc_pkg::SUM_W'(isbc_pkg::ONE_G_Q16);
      end
      // The offset is a mean of converted samples, so the corrected value
      // stays far inside the 32-bit range and never reaches saturation.
      corr[i]     = isbc_pkg::SUMO_W'($signed(pop_data.phys[i]))
                  + isbc_pkg::SUMO_W'($signed(offsets[i]));
      held_nxt[i] = isbc_pkg::OUT_W'(corr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      done_r  <= 1'b0;
      held_r  <= '0;
    end else begin
      out_v_r <= pop || (out_v_r && !out_ready);
      if (div_start) begin
        done_r <= 1'b1;
      end
      if (pop && is_apply) begin
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fresh_r <= is_apply;
      case (pop_data.cls)
        isbc_pkg::CLS_DROP: begin
          for (int i = 0; i < isbc_pkg::N_AXES; i++) begin
            sums_r[i] <= '0;
          end
        end
        isbc_pkg::CLS_ACC: begin
          for (int i = 0; i < isbc_pkg::N_AXES; i++) begin
            sums_r[i] <= sums_nxt[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/imu_sample_scale_and_bias_calibrate_unit.sv =====
// The unit converts six-axis IMU samples (three accelerometer and three gyroscope
// counts, 16-bit signed) into Q16.16 m/s^2 and rad/s and removes a zero offset
// that it learns itself after reset. A sample is new when status bits 1:0 are not
// both zero; every input word, new or not, yields exactly one output word. After
// reset the first new sample is dropped, the next CALIB_COUNT-1 are summed (one g
// taken off accel z), and the one after that closes calibration: calibrated rises
// and each offset becomes the negated, rounded mean of its sum. Until then, and
// for samples that are not new, the output repeats the held values with fresh low.
// Range registers (accel_range at byte 0, gyro_range at byte 4) must be written
// only while the unit is idle, which the unit does not enforce; offsets are not
// rescaled by a later range change. Throughput is one word per clock unless the
// output stalls; words pass the product register, queue and output register.
// When calibration closes, the rounded means are formed from the sums in the same
// clock that the closing word leaves the queue, so the very next word sees the
// offsets. Calibration never drops in_ready; only a stalled output side does.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU sample scale and bias calibration unit
// Top level: configuration registers, front end, queue, back end and divider.
// ----------------------------------------------------------------------------
module imu_sample_scale_and_bias_calibrate_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [isbc_pkg::PADDR_W-1:0]        paddr,
  input  logic [isbc_pkg::PDATA_W-1:0]        pwdata,
  output logic [isbc_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // Sample input.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [isbc_pkg::RAW_W-1:0]   in_accel_x_raw,
  input  logic signed [isbc_pkg::RAW_W-1:0]   in_accel_y_raw,
  input  logic signed [isbc_pkg::RAW_W-1:0]   in_accel_z_raw,
  input  logic signed [isbc_pkg::RAW_W-1:0]   in_gyro_x_raw,
  input  logic signed [isbc_pkg::RAW_W-1:0]   in_gyro_y_raw,
  input  logic signed [isbc_pkg::RAW_W-1:0]   in_gyro_z_raw,
  input  logic [isbc_pkg::STATUS_W-1:0]       in_sensor_status,
  // Result output.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [isbc_pkg::OUT_W-1:0]   out_accel_x_out,
  output logic signed [isbc_pkg::OUT_W-1:0]   out_accel_y_out,
  output logic signed [isbc_pkg::OUT_W-1:0]   out_accel_z_out,
  output logic signed [isbc_pkg::OUT_W-1:0]   out_gyro_x_out,
  output logic signed [isbc_pkg::OUT_W-1:0]   out_gyro_y_out,
  output logic signed [isbc_pkg::OUT_W-1:0]   out_gyro_z_out,
  output logic                                out_calibrated,
  output logic                                out_fresh
);

  logic [isbc_pkg::ACC_RANGE_W-1:0]                      accel_range_r;
  logic [isbc_pkg::GYR_RANGE_W-1:0]                      gyro_range_r;
  logic                                                  cfg_wr;
  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::RAW_W-1:0]      in_raw;
  logic                                                  q_full;
  logic                                                  q_push;
  isbc_pkg::entry_t                                      q_entry;
  logic                                                  q_pop;
  logic                                                  q_valid;
  isbc_pkg::entry_t                                      q_head;
  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::OFF_W-1:0]      offsets;
  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::SUM_W-1:0]      sums;
  logic                                                  div_start;
  logic [isbc_pkg::N_AXES-1:0][isbc_pkg::OUT_W-1:0]      held;

  // The register index is the word address; the write lands in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_range_r <= isbc_pkg::ACC_RANGE_RST;
      gyro_range_r  <= isbc_pkg::GYR_RANGE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        isbc_pkg::REG_IDX_ACCEL: accel_range_r <= pwdata[isbc_pkg::ACC_RANGE_W-1:0];
        isbc_pkg::REG_IDX_GYRO:  gyro_range_r  <= pwdata[isbc_pkg::GYR_RANGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      isbc_pkg::REG_IDX_ACCEL: prdata = isbc_pkg::PDATA_W'(accel_range_r);
      isbc_pkg::REG_IDX_GYRO:  prdata = isbc_pkg::PDATA_W'(gyro_range_r);
      default:                 prdata = '0;
    endcase
  end

  assign in_raw[0] = in_accel_x_raw;
  assign in_raw[1] = in_accel_y_raw;
  assign in_raw[2] = in_accel_z_raw;
  assign in_raw[3] = in_gyro_x_raw;
  assign in_raw[4] = in_gyro_y_raw;
  assign in_raw[5] = in_gyro_z_raw;

  // Front end: classification and conversion, one word per clock while the queue is not full.
  isbc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_raw      (in_raw),
    .in_status   (in_sensor_status),
    .accel_range (accel_range_r),
    .gyro_range  (gyro_range_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  // The queue lets the front end keep taking words while the back end waits
  // on the output.
  isbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_head)
  );

  isbc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (q_valid),
    .pop_data       (q_head),
    .pop            (q_pop),
    .offsets        (offsets),
    .div_start      (div_start),
    .sums           (sums),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .held           (held),
    .out_calibrated (out_calibrated),
    .out_fresh      (out_fresh)
  );

  isbc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .sums    (sums),
    .offsets (offsets)
  );

  assign out_accel_x_out = held[0];
  assign out_accel_y_out = held[1];
  assign out_accel_z_out = held[2];
  assign out_gyro_x_out  = held[3];
  assign out_gyro_y_out  = held[4];
  assign out_gyro_z_out  = held[5];

endmodule
`default_nettype wire

// ===== design/isbc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU calibration port checker
// Watches the result port of the unit; bound to the top level.
// ----------------------------------------------------------------------------
module isbc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [isbc_pkg::OUT_W-1:0]        out_accel_x_out,
  input logic [isbc_pkg::OUT_W-1:0]        out_gyro_z_out,
  input logic                              out_calibrated,
  input logic                              out_fresh
);

  logic                          seen_cal_r;
  logic [isbc_pkg::OUT_W-1:0]    prev_ax_r;
  logic [isbc_pkg::OUT_W-1:0]    prev_gz_r;

  // Last delivered values; held values are zero out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_cal_r <= 1'b0;
      prev_ax_r  <= '0;
      prev_gz_r  <= '0;
    end else if (out_valid && out_ready) begin
      seen_cal_r <= seen_cal_r || out_calibrated;
      prev_ax_r  <= out_accel_x_out;
      prev_gz_r  <= out_gyro_z_out;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accel_x_out) &&
      $stable(out_calibrated) && $stable(out_fresh))
    else $error("result word changed while stalled");

  a_fresh_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_fresh || out_calibrated)
    else $error("fresh word before calibration finished");

  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_cal_r |-> out_calibrated)
    else $error("calibrated flag dropped");

  a_held_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fresh |-> out_accel_x_out == prev_ax_r && out_gyro_z_out == prev_gz_r)
    else $error("held word differs from the last delivered word");

endmodule

bind imu_sample_scale_and_bias_calibrate_unit isbc_checker u_isbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_accel_x_out (out_accel_x_out),
  .out_gyro_z_out  (out_gyro_z_out),
  .out_calibrated  (out_calibrated),
  .out_fresh       (out_fresh)
);
`default_nettype wire
